// File: rtl/rfifo_pkg.sv
package rfifo_pkg;

	// operation codes carried in s_tuser
	localparam int FUNC_W = 3;
	typedef logic [FUNC_W-1:0] func_t;

	localparam func_t FUNC_PUSH    = 3'd0;
	localparam func_t FUNC_POP     = 3'd1;
	localparam func_t FUNC_PEEK    = 3'd2;
	localparam func_t FUNC_DISCARD = 3'd3;
	localparam func_t FUNC_FLUSH   = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_CAPACITY  = 2'd0;
	localparam cfg_idx_t CFG_OVERWRITE = 2'd1;

	// fixed field widths
	localparam int COUNT_W = 4;

endpackage

// File: rtl/ring_fifo_with_overwrite_core.sv
// channel | dir | signals                        | request contents
// --------+-----+--------------------------------+----------------------------------------
// s       | in  | s_tvalid s_tready s_tdata s_tuser | one operation: func, push_data, count
// m       | out | m_tvalid m_tready m_tdata      | one status per operation
// cfg     | in  | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// one operation is taken every cycle while the m side is not stalled; a request is held in the
// input register at acceptance and its result is then captured in the result register
// the rate is set by the single write port and the single read port of the entry store
// and the registered update of the head and tail indices
// reset clears the indices, sets capacity to 16 (clamped to MAX_DEPTH) and overwrite off;
// store contents are unknown after reset and are never read before being written
// a stalled m side holds the result register and in turn the input register
module ring_fifo_with_overwrite_core
	import rfifo_pkg::*;
#(
	parameter int MAX_DEPTH  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_tvalid,
	output logic                   s_tready,
	// push_data, discard_count, zero pad
	input  logic [((DATA_WIDTH+COUNT_W+7)/8)*8-1:0] s_tdata,
	// func
	input  logic [FUNC_W-1:0]      s_tuser,

	output logic                   m_tvalid,
	input  logic                   m_tready,
	// done_count, read_data, dropped_oldest, fill_count, is_full, is_empty, zero pad
	output logic [((DATA_WIDTH+2*COUNT_W+3+7)/8)*8-1:0] m_tdata,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int OUT_W   = ((DATA_WIDTH+2*COUNT_W+3+7)/8)*8;
	localparam int IW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;   // index width
	localparam int CW      = IW + 1;                                     // capacity width
	localparam int SW      = (CW > COUNT_W) ? CW : COUNT_W;              // discard math width
	localparam int CAP_RST = (MAX_DEPTH < 16) ? MAX_DEPTH : 16;

	// ring index advance with wrap at the active capacity
	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
			input logic [CW-1:0] cap);
		logic [CW-1:0] n;
		n = {1'b0, idx} + CW'(1);
		return (n >= cap) ? '0 : n[IW-1:0];
	endfunction

	// entries held between tail and head
	function automatic logic [CW-1:0] fill_of(input logic [IW-1:0] wi,
			input logic [IW-1:0] ri, input logic [CW-1:0] cap);
		logic [CW-1:0] f;
		if (wi >= ri) begin
			f = {1'b0, wi} - {1'b0, ri};
		end else begin
			f = cap - ({1'b0, ri} - {1'b0, wi});
		end
		return f;
	endfunction

	// control state
	logic [IW-1:0]         wi_q, ri_q;
	logic [CW-1:0]         cap_q;
	logic                  ovw_q;

	// input register
	logic                  valid_s1;
	func_t                 func_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	logic [COUNT_W-1:0]    ndisc_s1;

	// result register
	logic                  out_valid_q;
	logic [COUNT_W-1:0]    done_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic                  dropped_q;
	logic [COUNT_W-1:0]    fill_q;
	logic                  full_q, empty_q;

	// entry store and registered tail entry
	logic [DATA_WIDTH-1:0] store_q [MAX_DEPTH];
	logic [DATA_WIDTH-1:0] head_q;

	logic                  adv, exec;
	logic                  cfg_wr, cap_wr;
	logic [CW-1:0]         cap_new;
	logic                  full_cur, empty_cur;
	logic [CW-1:0]         fill_cur;
	logic [SW-1:0]         nd_eff;
	logic [SW:0]           disc_sum;
	logic [IW-1:0]         wi_op, ri_op, wi_next, ri_next;
	logic                  we;
	logic [COUNT_W-1:0]    done_op;
	logic [DATA_WIDTH-1:0] rd_op;
	logic                  dropped_op;
	logic [CW-1:0]         fill_op;

	// handshakes
	assign adv       = !out_valid_q || m_tready;
	assign exec      = valid_s1 && adv;
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cap_wr    = cfg_wr && (cfg_index == CFG_CAPACITY);

	// out of range capacity clamps to 2..MAX_DEPTH
	always_comb begin
		if (cfg_data < CFG_DATA_W'(2)) begin
			cap_new = CW'(2);
		end else if (int'(cfg_data) > MAX_DEPTH) begin
			cap_new = CW'(MAX_DEPTH);
		end else begin
			cap_new = CW'(cfg_data);
		end
	end

	// status before the operation
	assign empty_cur = (wi_q == ri_q);
	assign full_cur  = (wrap_inc(wi_q, cap_q) == ri_q);
	assign fill_cur  = fill_of(wi_q, ri_q, cap_q);

	// discard: drop the lesser of the count and the fill
	always_comb begin
		nd_eff   = (SW'(ndisc_s1) > SW'(fill_cur)) ? SW'(fill_cur) : SW'(ndisc_s1);
		disc_sum = (SW+1)'(ri_q) + (SW+1)'(nd_eff);
		if (disc_sum >= (SW+1)'(cap_q)) begin
			disc_sum = disc_sum - (SW+1)'(cap_q);
		end
	end

	// operation decode
	always_comb begin
		wi_op      = wi_q;
		ri_op      = ri_q;
		we         = 1'b0;
		done_op    = '0;
		rd_op      = '0;
		dropped_op = 1'b0;
		unique case (func_s1)
			FUNC_PUSH: begin
				if (!full_cur || ovw_q) begin
					we         = exec;
					wi_op      = wrap_inc(wi_q, cap_q);
					done_op    = COUNT_W'(1);
					// overwrite on full pushes the tail along
					if (full_cur) begin
						ri_op      = wrap_inc(ri_q, cap_q);
						dropped_op = 1'b1;
					end
				end
			end
			FUNC_POP, FUNC_PEEK: begin
				if (!empty_cur) begin
					rd_op   = head_q;
					done_op = COUNT_W'(1);
					if (func_s1 == FUNC_POP) begin
						ri_op = wrap_inc(ri_q, cap_q);
					end
				end
			end
			FUNC_DISCARD: begin
				ri_op   = disc_sum[IW-1:0];
				done_op = nd_eff[COUNT_W-1:0];
			end
			FUNC_FLUSH: begin
				wi_op = '0;
				ri_op = '0;
			end
			default: begin
			end
		endcase
	end

	assign fill_op = fill_of(wi_op, ri_op, cap_q);

	// capacity write flushes the queue
	always_comb begin
		if (cap_wr) begin
			wi_next = '0;
			ri_next = '0;
		end else if (exec) begin
			wi_next = wi_op;
			ri_next = ri_op;
		end else begin
			wi_next = wi_q;
			ri_next = ri_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q        <= '0;
			ri_q        <= '0;
			cap_q       <= CW'(CAP_RST);
			ovw_q       <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wi_q <= wi_next;
			ri_q <= ri_next;
			if (cap_wr) begin
				cap_q <= cap_new;
			end
			if (cfg_wr && (cfg_index == CFG_OVERWRITE)) begin
				ovw_q <= cfg_data[0];
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1  <= s_tuser;
			data_s1  <= s_tdata[DATA_WIDTH-1:0];
			ndisc_s1 <= s_tdata[DATA_WIDTH+COUNT_W-1:DATA_WIDTH];
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (exec) begin
			done_q    <= done_op;
			rd_q      <= rd_op;
			dropped_q <= dropped_op;
			fill_q    <= COUNT_W'(fill_op);
			full_q    <= (wrap_inc(wi_op, cap_q) == ri_op);
			empty_q   <= (wi_op == ri_op);
		end
	end

	// entry store: write at head, keep the tail entry registered with write bypass
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[wi_q] <= data_s1;
		end
		if (we && (wi_q == ri_next)) begin
			head_q <= data_s1;
		end else begin
			head_q <= store_q[ri_next];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({empty_q, full_q, fill_q, dropped_q, rd_q, done_q});

	// indices never leave the active ring
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wi_q < cap_q) && (ri_q < cap_q))
		else $error("ring index outside capacity");

	// empty state and zero fill agree
	a_fill_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty_cur == (fill_cur == '0))
		else $error("fill count disagrees with empty flag");

	// a refused push leaves the head alone
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (func_s1 == FUNC_PUSH) && full_cur && !ovw_q && !cap_wr |=>
		wi_q == $past(wi_q))
		else $error("refused push moved the head");

	// a dropped entry only comes with a single completed push
	a_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && dropped_q |-> (done_q == COUNT_W'(1)) && full_q && !empty_q)
		else $error("dropped flag without a completed push");

endmodule

// File: verif/ring_fifo_with_overwrite_core_tb.sv
`default_nettype none

module ring_fifo_with_overwrite_core_tb;
	import rfifo_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 16;
	localparam int DATA_W       = 32;
	localparam int S_DATA_W     = ((DATA_W + COUNT_W + 7) / 8) * 8;
	localparam int M_DATA_W     = ((DATA_W + 2 * COUNT_W + 3 + 7) / 8) * 8;
	localparam int STALL_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 200000;

	// operation codes the block must ignore
	localparam func_t FUNC_RSVD5 = 3'd5;
	localparam func_t FUNC_RSVD6 = 3'd6;
	localparam func_t FUNC_RSVD7 = 3'd7;

	// register indexes with no register behind them
	localparam cfg_idx_t CFG_RSVD2 = 2'd2;
	localparam cfg_idx_t CFG_RSVD3 = 2'd3;

	// status of one operation, compared field by field
	typedef struct packed {
		logic [COUNT_W-1:0] done_count;
		logic [DATA_W-1:0]  read_data;
		logic               dropped_oldest;
		logic [COUNT_W-1:0] fill_count;
		logic               is_full;
		logic               is_empty;
	} fifo_status_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// push_data, discard_count, zero pad
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	// func
	logic [FUNC_W-1:0]     s_tuser   = FUNC_PUSH;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// done_count, read_data, dropped_oldest, fill_count, is_full, is_empty, zero pad
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_CAPACITY;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// mirror of the queue: entries, head (write) and tail (read) indexes, registers
	logic [DATA_W-1:0] mirror_mem [DEPTH];
	int                head_idx   = 0;
	int                tail_idx   = 0;
	logic [4:0]        cap_reg    = 5'd16;
	logic              ovw_reg    = 1'b0;

	// statuses predicted for accepted requests, oldest first
	fifo_status_t status_q [$];

	int   err_cnt     = 0;
	int   cycle_cnt   = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	logic stall_req   = 1'b0;
	logic stall_ack   = 1'b0;
	int   stall_left  = 0;

	ring_fifo_with_overwrite_core #(
		.MAX_DEPTH (DEPTH),
		.DATA_WIDTH(DATA_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off whenever stall_req toggles
	always @(posedge clk) begin
		if (stall_req != stall_ack) begin
			stall_ack  <= stall_req;
			stall_left <= STALL_CYCLES;
			m_tready   <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic int wrap_next(input int idx, input int cap);
		return (idx + 1 >= cap) ? 0 : idx + 1;
	endfunction

	function automatic int queue_fill(input int cap);
		return (head_idx >= tail_idx) ? head_idx - tail_idx : cap - (tail_idx - head_idx);
	endfunction

	// applies one operation to the mirror and works out the status it reports
	task automatic apply_fifo_op(input func_t op, input logic [DATA_W-1:0] din,
			input logic [COUNT_W-1:0] ndrop, output fifo_status_t st);
		int cap;
		int nxt;
		int n;
		cap = (cap_reg < 2) ? 2 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
		st = '0;
		case (op)
			FUNC_PUSH: begin
				nxt = wrap_next(head_idx, cap);
				// full queue: refused, unless overwrite drops the oldest entry
				if (nxt != tail_idx || ovw_reg) begin
					mirror_mem[head_idx] = din;
					if (nxt == tail_idx) begin
						tail_idx = wrap_next(tail_idx, cap);
						st.dropped_oldest = 1'b1;
					end
					head_idx = nxt;
					st.done_count = COUNT_W'(1);
				end
			end
			FUNC_POP, FUNC_PEEK: begin
				if (head_idx != tail_idx) begin
					st.read_data = mirror_mem[tail_idx];
					if (op == FUNC_POP)
						tail_idx = wrap_next(tail_idx, cap);
					st.done_count = COUNT_W'(1);
				end
			end
			FUNC_DISCARD: begin
				// never drops more than the queue holds
				n = (int'(ndrop) > queue_fill(cap)) ? queue_fill(cap) : int'(ndrop);
				tail_idx = (tail_idx + n >= cap) ? tail_idx + n - cap : tail_idx + n;
				st.done_count = COUNT_W'(n);
			end
			FUNC_FLUSH: begin
				head_idx = 0;
				tail_idx = 0;
			end
			default: ;
		endcase
		st.fill_count = COUNT_W'(queue_fill(cap));
		st.is_full    = (wrap_next(head_idx, cap) == tail_idx);
		st.is_empty   = (head_idx == tail_idx);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// checks results, tracks register writes and predicts every accepted request
	always @(posedge clk) begin
		fifo_status_t got;
		fifo_status_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[3:0], m_tdata[35:4], m_tdata[36], m_tdata[40:37],
					m_tdata[41], m_tdata[42]};
				if (status_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, got);
					err_cnt++;
				end else begin
					want = status_q.pop_front();
					check_field("done_count", DATA_W'(want.done_count),
						DATA_W'(got.done_count));
					check_field("read_data", want.read_data, got.read_data);
					check_field("dropped_oldest", DATA_W'(want.dropped_oldest),
						DATA_W'(got.dropped_oldest));
					check_field("fill_count", DATA_W'(want.fill_count),
						DATA_W'(got.fill_count));
					check_field("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
					check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CAPACITY: begin
						// a capacity write also empties the queue
						cap_reg  = cfg_data;
						head_idx = 0;
						tail_idx = 0;
					end
					CFG_OVERWRITE: ovw_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				apply_fifo_op(s_tuser, s_tdata[DATA_W-1:0], s_tdata[DATA_W+COUNT_W-1:DATA_W], want);
				status_q.push_back(want);
			end
		end
	end

	// offers one request, idling first at random; returns at the accepting edge
	task automatic send_op(input func_t op, input logic [DATA_W-1:0] din,
			input logic [COUNT_W-1:0] ndrop);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(S_DATA_W - DATA_W - COUNT_W){1'b0}}, ndrop, din};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait until every predicted status has come back
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (status_q.size() != 0) @(posedge clk);
	endtask

	// register writes only happen with the queue pipeline empty
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] rand_entry();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// every operation but push on a freshly reset, empty queue
	task automatic test_empty_queue_ops;
		send_op(FUNC_POP, '0, '0);
		send_op(FUNC_PEEK, '1, '0);
		send_op(FUNC_DISCARD, '0, '1);
		send_op(FUNC_FLUSH, '0, '0);
		send_op(FUNC_RSVD5, '1, '1);
		send_op(FUNC_RSVD6, '0, '0);
		send_op(FUNC_RSVD7, '1, '1);
	endtask

	// all-zero and all-one entries through push, peek, discard and pop
	task automatic test_push_pop_extremes;
		send_op(FUNC_PUSH, '0, '0);
		send_op(FUNC_PUSH, '1, '1);
		send_op(FUNC_PEEK, '0, '0);
		send_op(FUNC_DISCARD, '0, 4'd1);
		send_op(FUNC_POP, '0, '0);
	endtask

	// one usable entry: refused push, then overwrite of the oldest
	task automatic test_small_capacity;
		write_reg(CFG_CAPACITY, 5'd2);
		send_op(FUNC_PUSH, 32'h5a5a_a5a5, '0);
		send_op(FUNC_PUSH, 32'hdead_beef, '0);
		write_reg(CFG_OVERWRITE, 5'd1);
		send_op(FUNC_PUSH, 32'hc001_d00d, '0);
		send_op(FUNC_PEEK, '0, '0);
		send_op(FUNC_POP, '0, '0);
	endtask

	// out of range capacities clamp; the unused indexes change nothing
	task automatic test_capacity_clamp;
		write_reg(CFG_CAPACITY, 5'd31);
		send_op(FUNC_PUSH, 32'h1234_5678, '0);
		send_op(FUNC_DISCARD, '0, 4'd15);
		send_op(FUNC_FLUSH, '0, '0);
		write_reg(CFG_RSVD2, 5'd31);
		write_reg(CFG_RSVD3, 5'd1);
		write_reg(CFG_CAPACITY, 5'd0);
		send_op(FUNC_PUSH, 32'h0000_0001, '0);
		send_op(FUNC_PUSH, 32'h8000_0000, '0);
		send_op(FUNC_POP, '0, '0);
		write_reg(CFG_OVERWRITE, 5'd0);
		write_reg(CFG_CAPACITY, 5'd1);
	endtask

	// segments of random operations, each with its own capacity, mode and push bias
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int segs);
		int         push_pct;
		int         r;
		logic [4:0] cap;
		func_t      op;
		logic [3:0] ndrop;
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		for (int s = 0; s < segs; s++) begin
			case ($urandom_range(9))
				0: cap = 5'd0;
				1: cap = 5'd1;
				2: cap = 5'd2;
				3: cap = 5'd3;
				4: cap = 5'd15;
				5, 6: cap = 5'd16;
				7: cap = 5'd31;
				default: cap = 5'($urandom_range(31));
			endcase
			write_reg(CFG_CAPACITY, cap);
			write_reg(CFG_OVERWRITE, 5'($urandom_range(1)));
			// push heavy segments fill the queue, pop heavy ones keep it near empty
			push_pct = $urandom_range(30, 75);
			for (int i = 0; i < 110; i++) begin
				if ($urandom_range(99) < push_pct) begin
					op = FUNC_PUSH;
				end else begin
					r = $urandom_range(99);
					if (r < 50)      op = FUNC_POP;
					else if (r < 70) op = FUNC_PEEK;
					else if (r < 88) op = FUNC_DISCARD;
					else if (r < 95) op = FUNC_FLUSH;
					else begin
						case ($urandom_range(2))
							0: op = FUNC_RSVD5;
							1: op = FUNC_RSVD6;
							default: op = FUNC_RSVD7;
						endcase
					end
				end
				ndrop = ($urandom_range(9) < 7) ? 4'($urandom_range(3))
					: 4'($urandom_range(15));
				send_op(op, rand_entry(), ndrop);
			end
		end
	endtask

	// result side holds off while requests keep coming, so the input stalls
	task automatic test_output_backpressure;
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		write_reg(CFG_CAPACITY, 5'd16);
		write_reg(CFG_OVERWRITE, 5'd1);
		stall_req <= ~stall_req;
		for (int i = 0; i < 40; i++)
			send_op((i % 4 == 3) ? FUNC_POP : FUNC_PUSH, rand_entry(), '0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue_ops();
		test_push_pop_extremes();
		test_small_capacity();
		test_capacity_clamp();
		test_random_traffic(18, 78, 6);
		test_random_traffic(78, 18, 6);
		test_random_traffic(0, 0, 6);
		test_output_backpressure();

		// let any stray result show up before the verdict
		drain();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: ring_fifo_with_overwrite_core.f
rtl/rfifo_pkg.sv
rtl/ring_fifo_with_overwrite_core.sv
verif/ring_fifo_with_overwrite_core_tb.sv
